// ===== hw/rtl/dtq_pkg.sv =====
// dtq_pkg: shared widths, action and result codes, and the slot table control struct
// used by the deadline timer queue top level and its slot store; no dependencies

package dtq_pkg;

	localparam int TIME_W          = 48;
	localparam int DELAY_W         = 32;
	localparam int ID_W            = 4;
	localparam int ACTION_W        = 2;
	localparam int KIND_W          = 2;
	localparam int MAX_TIMERS_DEF  = 16;

	localparam logic [ACTION_W-1:0] ACT_ADD  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_DEL  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK = 2'd2;

	localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXP  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DONE = 2'd3;

	typedef struct packed {
		logic dl_we;
		logic per_we;
		logic set_valid;
		logic clr_valid;
	} slot_ctl_t;

endpackage

// ===== hw/rtl/dtq_slot_store.sv =====
// dtq_slot_store: timer slot table with deadline and period memories and valid bits
// depends on dtq_pkg

module dtq_slot_store #(
	parameter int MaxTimers = dtq_pkg::MAX_TIMERS_DEF,
	parameter int IdxW      = $clog2(MaxTimers)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dtq_pkg::slot_ctl_t        ctl,
	input  logic [IdxW-1:0]           wr_idx,
	input  logic [dtq_pkg::TIME_W-1:0]  wr_deadline,
	input  logic [dtq_pkg::DELAY_W-1:0] wr_period,
	input  logic [IdxW-1:0]           rd_idx,
	input  logic [IdxW-1:0]           per_idx,
	output logic [MaxTimers-1:0]      valid,
	output logic [dtq_pkg::TIME_W-1:0]  rd_deadline,
	output logic [dtq_pkg::DELAY_W-1:0] rd_period
);
	import dtq_pkg::*;

	logic [TIME_W-1:0]  dl_mem_q  [MaxTimers];
	logic [DELAY_W-1:0] per_mem_q [MaxTimers];
	logic [TIME_W-1:0]  rd_deadline_q;
	logic [DELAY_W-1:0] rd_period_q;
	logic [MaxTimers-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (ctl.dl_we) begin
			dl_mem_q[wr_idx] <= wr_deadline;
		end
		if (ctl.per_we) begin
			per_mem_q[wr_idx] <= wr_period;
		end
		rd_deadline_q <= dl_mem_q[rd_idx];
		rd_period_q   <= per_mem_q[per_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.set_valid) begin
			valid_q[wr_idx] <= 1'b1;
		end else if (ctl.clr_valid) begin
			valid_q[wr_idx] <= 1'b0;
		end
	end

	assign valid       = valid_q;
	assign rd_deadline = rd_deadline_q;
	assign rd_period   = rd_period_q;

endmodule

// ===== hw/rtl/deadline_timer_queue.sv =====
// deadline_timer_queue: top level, sequencer around one saturating adder and one compare
// depends on dtq_pkg and dtq_slot_store
//
//   channel | signals                                          | role
//   in      | in_valid in_ready action now_ms after_ms          | add, delete, tick
//           | repeat_ms timer_id                               |
//   out     | out_valid out_ready kind timer_id_res ok          | replies, expiries,
//           | repeating last                                   | tick done
//
// add scans the valid bits for the lowest free slot, delete checks and clears one valid bit;
// a tick rescans the table after each expired timer it reports and ends with a final scan
// that finds none, each scan running on the one-entry-a-cycle deadline memory read and compare.
// arst_n clears the sequencer, the valid bits and the output valid bit.
// a stall on out holds the sequencer in its output step; in_ready is high only when idle.

module deadline_timer_queue #(
	parameter int MaxTimers = dtq_pkg::MAX_TIMERS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dtq_pkg::ACTION_W-1:0] action,
	input  logic [dtq_pkg::TIME_W-1:0]   now_ms,
	input  logic [dtq_pkg::DELAY_W-1:0]  after_ms,
	input  logic [dtq_pkg::DELAY_W-1:0]  repeat_ms,
	input  logic [dtq_pkg::ID_W-1:0]     timer_id,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dtq_pkg::KIND_W-1:0]   kind,
	output logic [dtq_pkg::ID_W-1:0]     timer_id_res,
	output logic                         ok,
	output logic                         repeating,
	output logic                         last
);
	import dtq_pkg::*;

	localparam int IdxW = $clog2(MaxTimers);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_ADD      = 8'b0000_0010,
		S_DEL      = 8'b0000_0100,
		S_SCAN     = 8'b0000_1000,
		S_SCAN_END = 8'b0001_0000,
		S_PICK     = 8'b0010_0000,
		S_REARM    = 8'b0100_0000,
		S_OUT      = 8'b1000_0000
	} state_t;

	state_t state_q, after_out_q;

	logic [TIME_W-1:0]   now_q;
	logic [DELAY_W-1:0]  after_q;
	logic [DELAY_W-1:0]  repeat_q;
	logic [ID_W-1:0]     id_q;

	logic [IdxW-1:0]     idx_q;
	logic [IdxW-1:0]     best_q;
	logic [TIME_W-1:0]   best_dl_q;
	logic                found_q;

	logic                scan_s1;
	logic                chk_s1;
	logic [IdxW-1:0]     idx_s1;

	logic [KIND_W-1:0]   pend_kind_q;
	logic [ID_W-1:0]     pend_id_q;
	logic                pend_ok_q;
	logic                pend_rep_q;
	logic                pend_last_q;

	logic                out_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [ID_W-1:0]     id_res_q;
	logic                ok_q;
	logic                rep_q;
	logic                last_q;

	slot_ctl_t           ctl;
	logic [IdxW-1:0]     wr_idx;
	logic [MaxTimers-1:0] valid;
	logic [TIME_W-1:0]   rd_deadline;
	logic [DELAY_W-1:0]  rd_period;

	logic [DELAY_W-1:0]  addend;
	logic [TIME_W:0]     sum;
	logic [TIME_W-1:0]   sat_sum;
	logic                del_hit;
	logic                out_free;
	logic                hit;

	// shared saturating adder
	assign addend  = (state_q == S_ADD) ? after_q : rd_period;
	assign sum     = {1'b0, now_q} + {{(TIME_W + 1 - DELAY_W){1'b0}}, addend};
	assign sat_sum = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

	assign del_hit  = (int'(id_q) < MaxTimers) && valid[IdxW'(id_q)];
	assign out_free = !out_valid_q || out_ready;

	// shared compare on the deadline read back
	assign hit = scan_s1 && chk_s1 && (rd_deadline < now_q)
	             && (!found_q || (rd_deadline < best_dl_q));

	always_comb begin
		ctl    = '0;
		wr_idx = idx_q;
		unique case (state_q)
			S_ADD: begin
				if (!valid[idx_q]) begin
					ctl.dl_we     = 1'b1;
					ctl.per_we    = 1'b1;
					ctl.set_valid = 1'b1;
				end
			end
			S_DEL: begin
				wr_idx        = IdxW'(id_q);
				ctl.clr_valid = del_hit;
			end
			S_REARM: begin
				wr_idx = best_q;
				if (rd_period != '0) begin
					ctl.dl_we = 1'b1;
				end else begin
					ctl.clr_valid = 1'b1;
				end
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	dtq_slot_store #(
		.MaxTimers (MaxTimers),
		.IdxW      (IdxW)
	) u_slots (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.wr_idx      (wr_idx),
		.wr_deadline (sat_sum),
		.wr_period   (repeat_q),
		.rd_idx      (idx_q),
		.per_idx     (best_q),
		.valid       (valid),
		.rd_deadline (rd_deadline),
		.rd_period   (rd_period)
	);

	// input capture and scan datapath
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_q    <= now_ms;
			after_q  <= after_ms;
			repeat_q <= repeat_ms;
			id_q     <= timer_id;
		end
		chk_s1 <= valid[idx_q];
		idx_s1 <= idx_q;
		if (hit) begin
			best_q    <= idx_s1;
			best_dl_q <= rd_deadline;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			after_out_q <= S_IDLE;
			idx_q       <= '0;
			found_q     <= 1'b0;
			scan_s1     <= 1'b0;
			pend_kind_q <= KIND_ADD;
			pend_id_q   <= '0;
			pend_ok_q   <= 1'b0;
			pend_rep_q  <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			scan_s1 <= (state_q == S_SCAN);
			if (hit) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						unique case (action)
							ACT_ADD: state_q <= S_ADD;
							ACT_DEL: state_q <= S_DEL;
							default: state_q <= S_SCAN;
						endcase
					end
				end
				S_ADD: begin
					pend_kind_q <= KIND_ADD;
					pend_rep_q  <= 1'b0;
					pend_last_q <= 1'b1;
					after_out_q <= S_IDLE;
					if (!valid[idx_q]) begin
						pend_id_q <= ID_W'(idx_q);
						pend_ok_q <= 1'b1;
						state_q   <= S_OUT;
					end else if (idx_q == IdxW'(MaxTimers - 1)) begin
						pend_id_q <= '0;
						pend_ok_q <= 1'b0;
						state_q   <= S_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DEL: begin
					pend_kind_q <= KIND_DEL;
					pend_id_q   <= id_q;
					pend_ok_q   <= del_hit;
					pend_rep_q  <= 1'b0;
					pend_last_q <= 1'b1;
					after_out_q <= S_IDLE;
					state_q     <= S_OUT;
				end
				S_SCAN: begin
					if (idx_q == IdxW'(MaxTimers - 1)) begin
						state_q <= S_SCAN_END;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SCAN_END: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (found_q) begin
						state_q <= S_REARM;
					end else begin
						pend_kind_q <= KIND_DONE;
						pend_id_q   <= '0;
						pend_ok_q   <= 1'b0;
						pend_rep_q  <= 1'b0;
						pend_last_q <= 1'b1;
						after_out_q <= S_IDLE;
						state_q     <= S_OUT;
					end
				end
				S_REARM: begin
					pend_kind_q <= KIND_EXP;
					pend_id_q   <= ID_W'(best_q);
					pend_ok_q   <= 1'b0;
					pend_rep_q  <= (rd_period != '0);
					pend_last_q <= 1'b0;
					after_out_q <= S_SCAN;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= after_out_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			kind_q   <= pend_kind_q;
			id_res_q <= pend_id_q;
			ok_q     <= pend_ok_q;
			rep_q    <= pend_rep_q;
			last_q   <= pend_last_q;
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign timer_id_res = id_res_q;
	assign ok           = ok_q;
	assign repeating    = rep_q;
	assign last         = last_q;

endmodule

// ===== test/deadline_timer_queue_tb.sv =====
`timescale 1ns / 1ps
// deadline_timer_queue_tb: self-checking bench for the timer queue, directed add, delete and
// tick transfers followed by random traffic under several idling and stall patterns
// depends on dtq_pkg and deadline_timer_queue

module deadline_timer_queue_tb;
	import dtq_pkg::*;

	localparam int SLOTS = MAX_TIMERS_DEF;
	localparam logic [ACTION_W-1:0] ACT_TICK_ALT = 2'd3;
	localparam logic [TIME_W-1:0] TIME_TOP = '1;
	localparam int RANDOM_ITEMS = 145;
	localparam int SETTLE_CYCLES = 120;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
		logic              ok;
		logic              repeating;
		logic              last;
	} timer_event_t;

	class timer_event_board;
		bit                 armed [SLOTS];
		logic [TIME_W-1:0]  due_ms [SLOTS];
		logic [DELAY_W-1:0] period_ms [SLOTS];
		timer_event_t       awaited [$];
		int requests;
		int results;
		int expiries;
		int full_adds;
		int errors;

		function logic [TIME_W-1:0] deadline_after(logic [TIME_W-1:0] base,
				logic [DELAY_W-1:0] delay);
			logic [TIME_W:0] sum;
			sum = {1'b0, base} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay};
			return sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];
		endfunction

		function void await_event(logic [KIND_W-1:0] k, logic [ID_W-1:0] id, logic ok_bit,
				logic rep_bit, logic last_bit);
			awaited.push_back({k, id, ok_bit, rep_bit, last_bit});
		endfunction

		function void note_request(logic [ACTION_W-1:0] act, logic [TIME_W-1:0] now,
				logic [DELAY_W-1:0] delay, logic [DELAY_W-1:0] period, logic [ID_W-1:0] id);
			int free;
			int best;
			requests++;
			case (act)
				ACT_ADD: begin
					free = -1;
					for (int i = 0; i < SLOTS; i++)
						if (!armed[i] && free < 0)
							free = i;
					if (free < 0) begin
						full_adds++;
						await_event(KIND_ADD, '0, 1'b0, 1'b0, 1'b1);
					end else begin
						armed[free] = 1'b1;
						due_ms[free] = deadline_after(now, delay);
						period_ms[free] = period;
						await_event(KIND_ADD, ID_W'(free), 1'b1, 1'b0, 1'b1);
					end
				end
				ACT_DEL: begin
					if (int'(id) < SLOTS && armed[id]) begin
						armed[id] = 1'b0;
						await_event(KIND_DEL, id, 1'b1, 1'b0, 1'b1);
					end else begin
						await_event(KIND_DEL, id, 1'b0, 1'b0, 1'b1);
					end
				end
				default: begin
					// earliest expired deadline first, lower id on a tie
					best = 0;
					while (best >= 0) begin
						best = -1;
						for (int i = 0; i < SLOTS; i++)
							if (armed[i] && due_ms[i] < now &&
									(best < 0 || due_ms[i] < due_ms[best]))
								best = i;
						if (best >= 0) begin
							expiries++;
							if (period_ms[best] != '0) begin
								due_ms[best] = deadline_after(now, period_ms[best]);
								await_event(KIND_EXP, ID_W'(best), 1'b0, 1'b1, 1'b0);
							end else begin
								armed[best] = 1'b0;
								await_event(KIND_EXP, ID_W'(best), 1'b0, 1'b0, 1'b0);
							end
						end
					end
					await_event(KIND_DONE, '0, 1'b0, 1'b0, 1'b1);
				end
			endcase
		endfunction

		function void check_result(timer_event_t got);
			timer_event_t want;
			results++;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result kind=%0d id=%0d ok=%0d repeating=%0d last=%0d",
					$time, got.kind, got.id, got.ok, got.repeating, got.last);
				return;
			end
			want = awaited.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: expected kind=%0d id=%0d ok=%0d repeating=%0d last=%0d",
					$time, want.kind, want.id, want.ok, want.repeating, want.last);
				$display("%0t:   actual kind=%0d id=%0d ok=%0d repeating=%0d last=%0d",
					$time, got.kind, got.id, got.ok, got.repeating, got.last);
			end
		endfunction

		function int armed_count();
			int n;
			n = 0;
			foreach (armed[i])
				n += armed[i];
			return n;
		endfunction

		function logic [ID_W-1:0] pick_armed();
			logic [ID_W-1:0] ids [$];
			for (int i = 0; i < SLOTS; i++)
				if (armed[i])
					ids.push_back(ID_W'(i));
			if (ids.size() == 0)
				return ID_W'($urandom_range(SLOTS - 1));
			return ids[$urandom_range(ids.size() - 1)];
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [ACTION_W-1:0] action;
	logic [TIME_W-1:0]   now_ms;
	logic [DELAY_W-1:0]  after_ms;
	logic [DELAY_W-1:0]  repeat_ms;
	logic [ID_W-1:0]     timer_id;
	logic                out_valid;
	logic                out_ready;
	logic [KIND_W-1:0]   kind;
	logic [ID_W-1:0]     timer_id_res;
	logic                ok;
	logic                repeating;
	logic                last;

	timer_event_board board;
	int idle_pct;
	int stall_pct;
	int quiet_cycles = 0;
	int idle_by_phase [4] = '{0, 85, 0, 22};
	int stall_by_phase [4] = '{0, 0, 85, 22};

	deadline_timer_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.now_ms(now_ms),
		.after_ms(after_ms),
		.repeat_ms(repeat_ms),
		.timer_id(timer_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.timer_id_res(timer_id_res),
		.ok(ok),
		.repeating(repeating),
		.last(last)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// result checking and watchdog on quiet cycles
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result({kind, timer_id_res, ok, repeating, last});
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				$time, WATCHDOG_LIMIT, board.awaited.size());
			$display("deadline_timer_queue: mismatch");
			$finish;
		end
	end

	function automatic logic [TIME_W-1:0] any_time();
		return TIME_W'({$urandom, $urandom});
	endfunction

	task automatic send_request(input logic [ACTION_W-1:0] act, input logic [TIME_W-1:0] now,
			input logic [DELAY_W-1:0] delay, input logic [DELAY_W-1:0] period,
			input logic [ID_W-1:0] id);
		int gap;
		gap = 0;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		now_ms <= now;
		after_ms <= delay;
		repeat_ms <= period;
		timer_id <= id;
		do @(posedge clk); while (!in_ready);
		board.note_request(act, now, delay, period, id);
	endtask

	initial begin
		logic [TIME_W-1:0]  clock_ms;
		logic [DELAY_W-1:0] delay;
		logic [DELAY_W-1:0] period;
		int r;
		int add_cut;
		board = new();
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_ADD;
		now_ms = '0;
		after_ms = '0;
		repeat_ms = '0;
		timer_id = '0;
		out_ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// empty table, delete of a free slot, fill, full table, tick that expires every timer
		send_request(ACT_TICK, '0, '1, '1, '1);
		send_request(ACT_DEL, TIME_TOP, '0, '0, '0);
		for (int i = 0; i < SLOTS; i++) begin
			period = (i == SLOTS - 1) ? '1 : ((i % 2) ? DELAY_W'(i * 3) : '0);
			send_request(ACT_ADD, 48'd100, DELAY_W'((i % 3) * 7), period, ID_W'(i));
		end
		send_request(ACT_ADD, 48'd100, 32'd1, 32'd1, '0);
		send_request(ACT_TICK, 48'd200, '0, '0, '0);
		send_request(ACT_DEL, '0, '0, '0, ID_W'(SLOTS - 1));
		send_request(ACT_DEL, '0, '0, '0, ID_W'(SLOTS - 1));
		// saturating deadline, then rearms that saturate at the top of the time range
		send_request(ACT_ADD, TIME_TOP, '1, '0, '0);
		send_request(ACT_TICK, TIME_TOP, '0, '0, '0);
		send_request(ACT_TICK_ALT, TIME_TOP, '1, '1, '1);

		clock_ms = 48'd1000;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			idle_pct = idle_by_phase[k * 4 / RANDOM_ITEMS];
			stall_pct = stall_by_phase[k * 4 / RANDOM_ITEMS];
			add_cut = 45 - 2 * board.armed_count();
			r = $urandom_range(99);
			if (r < add_cut) begin
				delay = ($urandom_range(3) == 0) ? $urandom : $urandom_range(80);
				case ($urandom_range(3))
					0, 1: period = '0;
					2: period = $urandom_range(50, 1);
					default: period = $urandom_range(1) ? $urandom : $urandom_range(50, 1);
				endcase
				send_request(ACT_ADD, ($urandom_range(9) == 0) ? any_time() : clock_ms,
					delay, period, ID_W'($urandom));
			end else if (r < 60) begin
				send_request(ACT_DEL, any_time(), $urandom, $urandom,
					($urandom_range(4) != 0) ? board.pick_armed() :
						ID_W'($urandom_range(SLOTS - 1)));
			end else begin
				case ($urandom_range(19))
					0: clock_ms = any_time();
					1: clock_ms = TIME_TOP - TIME_W'($urandom_range(200));
					default: clock_ms = clock_ms + TIME_W'($urandom_range(60));
				endcase
				send_request((r >= 95) ? ACT_TICK_ALT : ACT_TICK, clock_ms, $urandom, $urandom,
					ID_W'($urandom));
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d requests and %0d results: %0d expiries, %0d adds on a full table",
			board.requests, board.results, board.expiries, board.full_adds);
		$display("traffic ran free-flowing, with sparse input, heavy output stalls and both");
		if (board.errors == 0 && board.awaited.size() == 0)
			$display("deadline_timer_queue: match");
		else
			$display("deadline_timer_queue: mismatch");
		$finish;
	end

endmodule
